// ===== rtl/core/dhfk_pkg.sv =====
// ----------------------------------------------------------------------------
// dhfk_pkg
// Shared types, constants and arithmetic helpers for the DH kinematics block.
// ----------------------------------------------------------------------------
package dhfk_pkg;

  localparam int MAX_JOINTS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic signed [32:0] PI_Q30 = 33'sd3373259426;
  localparam logic [30:0]        ONE_U  = 31'd1073741824;

  typedef struct packed {
    logic [13:0] r;
    logic [1:0]  quad;
    logic        swap;
  } angle_t;

  typedef struct packed {
    angle_t             theta;
    angle_t             alpha;
    logic signed [31:0] a;
    logic signed [31:0] d;
    logic               last;
  } joint_t;

  // Fold a turn fraction into quadrant and octant phase.
  function automatic angle_t classify(input logic [15:0] ang);
    angle_t res;
    logic [13:0] f;
    f        = ang[13:0];
    res.quad = ang[15:14];
    res.swap = (f > 14'd8192);
    res.r    = res.swap ? 14'(15'd16384 - {1'b0, f}) : f;
    return res;
  endfunction

  // Horner divisors: sine series first, cosine series second.
  function automatic logic [7:0] horner_k(input logic cos_ph, input logic [2:0] idx);
    logic [7:0] k;
    if (!cos_ph) begin
      case (idx)
        3'd0:    k = 8'd110;
        3'd1:    k = 8'd72;
        3'd2:    k = 8'd42;
        3'd3:    k = 8'd20;
        default: k = 8'd6;
      endcase
    end else begin
      case (idx)
        3'd0:    k = 8'd132;
        3'd1:    k = 8'd90;
        3'd2:    k = 8'd56;
        3'd3:    k = 8'd30;
        3'd4:    k = 8'd12;
        default: k = 8'd2;
      endcase
    end
    return k;
  endfunction

  // floor(2^32 / k) for each divisor above.
  function automatic logic [31:0] horner_recip(input logic cos_ph, input logic [2:0] idx);
    logic [31:0] m;
    if (!cos_ph) begin
      case (idx)
        3'd0:    m = 32'd39045157;
        3'd1:    m = 32'd59652323;
        3'd2:    m = 32'd102261126;
        3'd3:    m = 32'd214748364;
        default: m = 32'd715827882;
      endcase
    end else begin
      case (idx)
        3'd0:    m = 32'd32537631;
        3'd1:    m = 32'd47721858;
        3'd2:    m = 32'd76695844;
        3'd3:    m = 32'd143165576;
        3'd4:    m = 32'd357913941;
        default: m = 32'd2147483648;
      endcase
    end
    return m;
  endfunction

  // Shift right by 30, rounding half away from zero.
  function automatic logic signed [37:0] round30(input logic signed [67:0] p);
    logic [67:0] m;
    logic [67:0] q;
    m = p[67] ? 68'(-p) : 68'(p);
    q = (m + 68'd536870912) >> 30;
    return p[67] ? -$signed(q[37:0]) : $signed(q[37:0]);
  endfunction

endpackage

// ===== rtl/core/dhfk_joint_if.sv =====
// ----------------------------------------------------------------------------
// dhfk_joint_if
// Joint item channel: angles, link length and offset, chain end mark.
// ----------------------------------------------------------------------------
interface dhfk_joint_if;
  logic               valid;
  logic               ready;
  logic [15:0]        joint_angle;
  logic [15:0]        twist_angle;
  logic signed [31:0] link_length;
  logic signed [31:0] link_offset;
  logic               last_joint;

  modport source (output valid, joint_angle, twist_angle, link_length, link_offset,
                  last_joint, input ready);
  modport sink   (input valid, joint_angle, twist_angle, link_length, link_offset,
                  last_joint, output ready);
endinterface

// ===== rtl/core/dhfk_pos_if.sv =====
// ----------------------------------------------------------------------------
// dhfk_pos_if
// Position item channel: frame origin, joint index and status flags.
// ----------------------------------------------------------------------------
interface dhfk_pos_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [2:0]         joint_index;
  logic               end_effector;
  logic               overflow;

  modport source (output valid, pos_x, pos_y, pos_z, joint_index, end_effector, overflow,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, joint_index, end_effector, overflow,
                  output ready);
endinterface

// ===== rtl/core/dhfk_front.sv =====
// ----------------------------------------------------------------------------
// dhfk_front
// Accepts joint items, folds both angles into octant form, pushes to queue.
// ----------------------------------------------------------------------------
module dhfk_front (
  dhfk_joint_if.sink       joint_in,
  input  logic             full,
  output logic             push,
  output dhfk_pkg::joint_t push_data
);
  import dhfk_pkg::*;

  assign joint_in.ready  = !full;
  assign push            = joint_in.valid && !full;
  assign push_data.theta = classify(joint_in.joint_angle);
  assign push_data.alpha = classify(joint_in.twist_angle);
  assign push_data.a     = joint_in.link_length;
  assign push_data.d     = joint_in.link_offset;
  assign push_data.last  = joint_in.last_joint;

endmodule

// ===== rtl/core/dhfk_queue.sv =====
// ----------------------------------------------------------------------------
// dhfk_queue
// Small FIFO of classified joint items between front and back.
// ----------------------------------------------------------------------------
module dhfk_queue #(
  parameter int DEPTH = dhfk_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dhfk_pkg::joint_t push_data,
  output logic             full,
  input  logic             pop,
  output dhfk_pkg::joint_t pop_data,
  output logic             pop_valid
);
  import dhfk_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  joint_t          mem [DEPTH];
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/dhfk_back.sv =====
// ----------------------------------------------------------------------------
// dhfk_back
// Sequencer around one shared 33x33 multiplier: sine/cosine by Horner series,
// DH terms, position update, rotation update, then the output register.
// ----------------------------------------------------------------------------
module dhfk_back #(
  parameter int MAX_JOINTS = dhfk_pkg::MAX_JOINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  dhfk_pkg::joint_t q_data,
  output logic             q_pop,
  dhfk_pos_if.source       pos
);
  import dhfk_pkg::*;

  localparam int         TOP_I     = (MAX_JOINTS - 1 < 7) ? MAX_JOINTS - 1 : 7;
  localparam logic [2:0] INDEX_TOP = 3'(TOP_I);

  typedef enum logic [11:0] {
    S_IDLE = 12'h001,
    S_X    = 12'h002,
    S_X2   = 12'h004,
    S_HA   = 12'h008,
    S_HB   = 12'h010,
    S_HC   = 12'h020,
    S_SFIN = 12'h040,
    S_ANG  = 12'h080,
    S_DH   = 12'h100,
    S_POS  = 12'h200,
    S_ROT  = 12'h400,
    S_OUT  = 12'h800
  } state_t;

  state_t             state;
  joint_t             jt;
  logic               sel;
  logic               cph;
  logic [2:0]         hk;
  logic [1:0]         ri;
  logic [1:0]         rj;
  logic [1:0]         rk;
  logic [29:0]        x;
  logic [29:0]        x2;
  logic [30:0]        t;
  logic [30:0]        n;
  logic [30:0]        q0;
  logic [30:0]        s0;
  logic signed [31:0] st;
  logic signed [31:0] ct;
  logic signed [31:0] sa;
  logic signed [31:0] ca;
  logic signed [31:0] dh1;
  logic signed [31:0] dh2;
  logic signed [31:0] dh4;
  logic signed [31:0] dh5;
  logic signed [32:0] tdh0;
  logic signed [32:0] tdh1;
  logic signed [67:0] acc;
  logic signed [31:0] rot    [9];
  logic signed [31:0] newrot [9];
  logic signed [31:0] trn    [3];
  logic [2:0]         cnt;
  logic               ovf;
  logic               ov;
  logic signed [31:0] ox;
  logic signed [31:0] oy;
  logic signed [31:0] oz;
  logic [2:0]         oidx;
  logic               oee;
  logic               oovf;

  angle_t             cur;
  logic [7:0]         kv;
  logic [31:0]        mv;
  logic               last_k;
  logic [3:0]         ridx;
  logic [3:0]         nidx;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] prod;
  logic [65:0]        pr14;
  logic [65:0]        pr29;
  logic signed [67:0] acc_sum;
  logic signed [37:0] rnd_p;
  logic signed [37:0] rnd_a;
  logic signed [37:0] psum;
  logic signed [31:0] psat;
  logic               phit;
  logic signed [31:0] rclamp;
  logic [30:0]        rem;
  logic [30:0]        q;
  logic [30:0]        c0;
  logic [30:0]        sclamp;
  logic [30:0]        su;
  logic [30:0]        cu;
  logic signed [31:0] sp;
  logic signed [31:0] cp;
  logic signed [31:0] sn;
  logic signed [31:0] cs;
  logic signed [32:0] dhop;
  logic signed [32:0] tdop;
  logic               load;

  assign cur    = sel ? jt.alpha : jt.theta;
  assign kv     = horner_k(cph, hk);
  assign mv     = horner_recip(cph, hk);
  assign last_k = cph ? (hk == 3'd5) : (hk == 3'd4);
  assign ridx   = 4'(ri) * 4'd3 + 4'(rk);
  assign nidx   = 4'(ri) * 4'd3 + 4'(rj);
  assign load   = !ov || pos.ready;
  assign q_pop  = (state == S_IDLE) && q_valid;

  always_comb begin
    case (rk)
      2'd0:    tdop = tdh0;
      2'd1:    tdop = tdh1;
      default: tdop = 33'(jt.d);
    endcase
    case ({rk, rj})
      4'b0000: dhop = 33'(ct);
      4'b0001: dhop = 33'(dh1);
      4'b0010: dhop = 33'(dh2);
      4'b0100: dhop = 33'(st);
      4'b0101: dhop = 33'(dh4);
      4'b0110: dhop = 33'(dh5);
      4'b1001: dhop = 33'(sa);
      4'b1010: dhop = 33'(ca);
      default: dhop = '0;
    endcase
  end

  always_comb begin
    unique case (state)
      S_X: begin
        ma = {19'd0, cur.r};
        mb = PI_Q30;
      end
      S_X2: begin
        ma = {3'd0, x};
        mb = {3'd0, x};
      end
      S_HA: begin
        ma = {3'd0, x2};
        mb = {2'd0, t};
      end
      S_HB: begin
        ma = {2'd0, n};
        mb = {1'b0, mv};
      end
      S_HC: begin
        ma = {2'd0, q0};
        mb = {25'd0, kv};
      end
      S_SFIN: begin
        ma = {3'd0, x};
        mb = {2'd0, t};
      end
      S_DH: begin
        case (hk)
          3'd0:    begin ma = 33'(ca);   mb = 33'(st); end
          3'd1:    begin ma = 33'(sa);   mb = 33'(st); end
          3'd2:    begin ma = 33'(ct);   mb = 33'(ca); end
          3'd3:    begin ma = 33'(ct);   mb = 33'(sa); end
          3'd4:    begin ma = 33'(jt.a); mb = 33'(ct); end
          default: begin ma = 33'(jt.a); mb = 33'(st); end
        endcase
      end
      S_POS: begin
        ma = 33'(rot[ridx]);
        mb = tdop;
      end
      S_ROT: begin
        ma = 33'(rot[ridx]);
        mb = dhop;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    prod    = ma * mb;
    pr14    = $unsigned(prod) + 66'd16384;
    pr29    = $unsigned(prod) + 66'd536870912;
    acc_sum = acc + 68'(prod);
    rnd_p   = round30(68'(prod));
    rnd_a   = round30(acc_sum);

    psum = rnd_a + 38'(trn[ri]);
    phit = 1'b0;
    if (psum > 38'sd2147483647) begin
      psat = 32'sh7FFFFFFF;
      phit = 1'b1;
    end else if (psum < -38'sd2147483648) begin
      psat = 32'sh80000000;
      phit = 1'b1;
    end else begin
      psat = psum[31:0];
    end

    if (rnd_a > 38'sd1073741824) begin
      rclamp = 32'sd1073741824;
    end else if (rnd_a < -38'sd1073741824) begin
      rclamp = -32'sd1073741824;
    end else begin
      rclamp = rnd_a[31:0];
    end

    rem    = n - prod[30:0];
    q      = (rem >= 31'(kv)) ? q0 + 31'd1 : q0;
    c0     = (t > ONE_U) ? ONE_U : t;
    sclamp = (pr29[60:30] > ONE_U) ? ONE_U : pr29[60:30];
    su     = cur.swap ? c0 : s0;
    cu     = cur.swap ? s0 : c0;
    sp     = {1'b0, su};
    cp     = {1'b0, cu};
    case (cur.quad)
      2'd0:    begin sn = sp;  cs = cp;  end
      2'd1:    begin sn = cp;  cs = -sp; end
      2'd2:    begin sn = -sp; cs = -cp; end
      default: begin sn = -cp; cs = sp;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
      cnt   <= '0;
      ovf   <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        rot[i] <= (i % 4 == 0) ? 32'sd1073741824 : '0;
      end
      for (int i = 0; i < 3; i++) begin
        trn[i] <= '0;
      end
    end else begin
      if (pos.valid && pos.ready && (state != S_OUT)) begin
        ov <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            jt    <= q_data;
            sel   <= 1'b0;
            state <= S_X;
          end
        end
        S_X: begin
          x     <= pr14[44:15];
          state <= S_X2;
        end
        S_X2: begin
          x2    <= pr29[59:30];
          t     <= ONE_U;
          cph   <= 1'b0;
          hk    <= '0;
          state <= S_HA;
        end
        S_HA: begin
          n     <= {1'b0, pr29[59:30]} + 31'(kv >> 1);
          state <= S_HB;
        end
        S_HB: begin
          q0    <= prod[62:32];
          state <= S_HC;
        end
        S_HC: begin
          t <= ONE_U - q;
          if (last_k) begin
            state <= cph ? S_ANG : S_SFIN;
          end else begin
            hk    <= hk + 3'd1;
            state <= S_HA;
          end
        end
        S_SFIN: begin
          s0    <= sclamp;
          t     <= ONE_U;
          cph   <= 1'b1;
          hk    <= '0;
          state <= S_HA;
        end
        S_ANG: begin
          if (!sel) begin
            st    <= sn;
            ct    <= cs;
            sel   <= 1'b1;
            state <= S_X;
          end else begin
            sa    <= sn;
            ca    <= cs;
            hk    <= '0;
            state <= S_DH;
          end
        end
        S_DH: begin
          case (hk)
            3'd0:    dh1  <= -rnd_p[31:0];
            3'd1:    dh2  <= rnd_p[31:0];
            3'd2:    dh4  <= rnd_p[31:0];
            3'd3:    dh5  <= -rnd_p[31:0];
            3'd4:    tdh0 <= rnd_p[32:0];
            default: tdh1 <= rnd_p[32:0];
          endcase
          if (hk == 3'd5) begin
            ri    <= '0;
            rj    <= '0;
            rk    <= '0;
            acc   <= '0;
            state <= S_POS;
          end else begin
            hk <= hk + 3'd1;
          end
        end
        S_POS: begin
          if (rk == 2'd2) begin
            acc     <= '0;
            rk      <= '0;
            trn[ri] <= psat;
            if (phit) begin
              ovf <= 1'b1;
            end
            if (ri == 2'd2) begin
              ri    <= '0;
              state <= S_ROT;
            end else begin
              ri <= ri + 2'd1;
            end
          end else begin
            acc <= acc_sum;
            rk  <= rk + 2'd1;
          end
        end
        S_ROT: begin
          if (rk == 2'd2) begin
            acc          <= '0;
            rk           <= '0;
            newrot[nidx] <= rclamp;
            if (rj == 2'd2) begin
              rj <= '0;
              if (ri == 2'd2) begin
                state <= S_OUT;
              end else begin
                ri <= ri + 2'd1;
              end
            end else begin
              rj <= rj + 2'd1;
            end
          end else begin
            acc <= acc_sum;
            rk  <= rk + 2'd1;
          end
        end
        S_OUT: begin
          if (load) begin
            ov    <= 1'b1;
            ox    <= trn[0];
            oy    <= trn[1];
            oz    <= trn[2];
            oidx  <= cnt;
            oee   <= jt.last;
            oovf  <= ovf;
            state <= S_IDLE;
            if (jt.last) begin
              cnt <= '0;
              ovf <= 1'b0;
              for (int i = 0; i < 9; i++) begin
                rot[i] <= (i % 4 == 0) ? 32'sd1073741824 : '0;
              end
              for (int i = 0; i < 3; i++) begin
                trn[i] <= '0;
              end
            end else begin
              for (int i = 0; i < 9; i++) begin
                rot[i] <= newrot[i];
              end
              if (cnt < INDEX_TOP) begin
                cnt <= cnt + 3'd1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pos.valid        = ov;
  assign pos.pos_x        = ox;
  assign pos.pos_y        = oy;
  assign pos.pos_z        = oz;
  assign pos.joint_index  = oidx;
  assign pos.end_effector = oee;
  assign pos.overflow     = oovf;

  a_index_top: assert property (@(posedge clk) disable iff (rst)
    pos.valid |-> (pos.joint_index <= INDEX_TOP))
    else $error("joint index past top");

  a_chain_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && load && jt.last) |=>
      (cnt == 3'd0 && !ovf && rot[0] == 32'sd1073741824 && trn[0] == 32'sd0))
    else $error("chain state not cleared after end effector");

  a_recip_err: assert property (@(posedge clk) disable iff (rst)
    (state == S_HC) |-> (rem < (31'(kv) << 1)))
    else $error("reciprocal quotient off by more than one");

  a_rot_bound: assert property (@(posedge clk) disable iff (rst)
    (rot[4] <= 32'sd1073741824 && rot[4] >= -32'sd1073741824))
    else $error("rotation entry out of range");

endmodule

// ===== rtl/core/dh_forward_kinematics_top.sv =====
// ----------------------------------------------------------------------------
// dh_forward_kinematics_top
// Denavit-Hartenberg forward kinematics, one serial-chain joint per item.
//
// joint_in carries one joint per item: joint and twist angle as turn
// fractions, link length and offset in Q16.16, and a last-joint mark.
// pos_out carries one item per joint: the frame origin in Q16.16, the joint
// index, the end-effector mark and a sticky saturation flag for the chain.
// A two-entry queue sits between the input side and the compute sequencer,
// so up to three joints are taken while a result waits on pos_out: one in
// the sequencer and two in the queue.
// Each joint passes from the queue to the output register through the sine/
// cosine series for each angle, the DH terms, the position update and the
// rotation update, all through one shared 33x33 multiplier.
// The output register holds its item while pos_out.ready is low; the
// sequencer then waits in its final step and the queue fills up.
// Reset clears the queue and the output valid, and sets the transform to
// identity with joint index and overflow flag at zero. After a last joint the
// chain state returns to that same reset state.
// ----------------------------------------------------------------------------
module dh_forward_kinematics_top #(
  parameter int MAX_JOINTS = dhfk_pkg::MAX_JOINTS_DEF
) (
  input logic        clk,
  input logic        rst,
  dhfk_joint_if.sink joint_in,
  dhfk_pos_if.source pos_out
);
  import dhfk_pkg::*;

  logic   push;
  logic   full;
  logic   pop;
  logic   q_valid;
  joint_t push_data;
  joint_t q_data;

  dhfk_front u_front (
    .joint_in  (joint_in),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  dhfk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (q_data),
    .pop_valid (q_valid)
  );

  dhfk_back #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (pop),
    .pos     (pos_out)
  );

endmodule

// ===== tb/dh_forward_kinematics_checker.sv =====
// ----------------------------------------------------------------------------
// dh_forward_kinematics_checker
// Watches both channels, computes the expected frame origin, index and flags
// of every accepted joint and compares them with each accepted position item.
// ----------------------------------------------------------------------------
module dh_forward_kinematics_checker #(
  parameter int MAX_JOINTS = dhfk_pkg::MAX_JOINTS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  dhfk_joint_if    joint_in,
  dhfk_pos_if      pos_out,
  output int       fail_count,
  output int       pending
);

  localparam longint ONE = 64'sd1 << 30;
  localparam int TOP_IDX = (MAX_JOINTS - 1) < 7 ? (MAX_JOINTS - 1) : 7;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [2:0]         idx;
    logic               ee;
    logic               ovf;
  } pos_item_t;

  pos_item_t expected_pos[$];
  longint rot[9];
  longint trans[3];
  int joint_cnt;
  bit ovf_seen;

  function automatic longint rnd30(longint p);
    longint m;
    m = (p < 0) ? -p : p;
    m = (m + (64'sd1 << 29)) >>> 30;
    return (p < 0) ? -m : m;
  endfunction

  function automatic void series(int r, output longint s, output longint c);
    int sk[5];
    int ck[6];
    longint x;
    longint x2;
    longint t;
    sk = '{110, 72, 42, 20, 6};
    ck = '{132, 90, 56, 30, 12, 2};
    x = (longint'(r) * 64'sd3373259426 + (64'sd1 << 14)) >>> 15;
    x2 = (x * x + (64'sd1 << 29)) >>> 30;
    t = ONE;
    foreach (sk[i]) t = ONE - ((((x2 * t + (64'sd1 << 29)) >>> 30) + sk[i] / 2) / sk[i]);
    t = (x * t + (64'sd1 << 29)) >>> 30;
    s = (t > ONE) ? ONE : t;
    t = ONE;
    foreach (ck[i]) t = ONE - ((((x2 * t + (64'sd1 << 29)) >>> 30) + ck[i] / 2) / ck[i]);
    c = (t > ONE) ? ONE : t;
  endfunction

  function automatic void turn_trig(logic [15:0] ang, output longint s, output longint c);
    longint s0;
    longint c0;
    int f;
    f = ang[13:0];
    if (f <= 8192) series(f, s0, c0);
    else series(16384 - f, c0, s0);
    case (ang[15:14])
      2'd0: begin s = s0;  c = c0;  end
      2'd1: begin s = c0;  c = -s0; end
      2'd2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endfunction

  function automatic void chain_clear();
    foreach (rot[i]) rot[i] = (i % 4 == 0) ? ONE : 0;
    foreach (trans[i]) trans[i] = 0;
    joint_cnt = 0;
    ovf_seen = 0;
  endfunction

  function automatic pos_item_t advance_joint(logic [15:0] th, logic [15:0] al,
                                              logic signed [31:0] a, logic signed [31:0] d,
                                              logic last);
    longint st, ct, sa, ca, acc;
    longint dh[9];
    longint tdh[3];
    longint nr[9];
    longint p[3];
    pos_item_t e;
    turn_trig(th, st, ct);
    turn_trig(al, sa, ca);
    dh = '{ct, -rnd30(ca * st), rnd30(sa * st), st, rnd30(ct * ca), -rnd30(ct * sa),
           0, sa, ca};
    tdh = '{rnd30(longint'(a) * ct), rnd30(longint'(a) * st), longint'(d)};
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += rot[i*3+k] * tdh[k];
      acc = rnd30(acc) + trans[i];
      if (acc > 64'sd2147483647) begin
        acc = 64'sd2147483647;
        ovf_seen = 1;
      end else if (acc < -64'sd2147483648) begin
        acc = -64'sd2147483648;
        ovf_seen = 1;
      end
      p[i] = acc;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rot[i*3+k] * dh[k*3+j];
        acc = rnd30(acc);
        if (acc > ONE) acc = ONE;
        if (acc < -ONE) acc = -ONE;
        nr[i*3+j] = acc;
      end
    rot = nr;
    trans = p;
    if (joint_cnt > TOP_IDX) joint_cnt = TOP_IDX;
    e.x = p[0][31:0];
    e.y = p[1][31:0];
    e.z = p[2][31:0];
    e.idx = joint_cnt[2:0];
    e.ee = last;
    e.ovf = ovf_seen;
    if (last) chain_clear();
    else if (joint_cnt < TOP_IDX) joint_cnt++;
    return e;
  endfunction

  assign pending = expected_pos.size();

  always @(posedge clk) begin
    pos_item_t e;
    if (rst) begin
      chain_clear();
      expected_pos.delete();
      fail_count <= 0;
    end else begin
      if (joint_in.valid && joint_in.ready)
        expected_pos.push_back(advance_joint(joint_in.joint_angle, joint_in.twist_angle,
                                             joint_in.link_length, joint_in.link_offset,
                                             joint_in.last_joint));
      if (pos_out.valid && pos_out.ready) begin
        if (expected_pos.size() == 0) begin
          $display("%0t: unexpected position item x=%h", $time, pos_out.pos_x);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_pos.pop_front();
          if (pos_out.pos_x !== e.x || pos_out.pos_y !== e.y || pos_out.pos_z !== e.z ||
              pos_out.joint_index !== e.idx || pos_out.end_effector !== e.ee ||
              pos_out.overflow !== e.ovf) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h idx=%0d ee=%b ovf=%b", $time,
                     e.x, e.y, e.z, e.idx, e.ee, e.ovf);
            $display("%0t:          actual x=%h y=%h z=%h idx=%0d ee=%b ovf=%b", $time,
                     pos_out.pos_x, pos_out.pos_y, pos_out.pos_z, pos_out.joint_index,
                     pos_out.end_effector, pos_out.overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/dh_forward_kinematics_top_test.sv =====
// ----------------------------------------------------------------------------
// dh_forward_kinematics_top_test
// Drives directed and random joint chains into the kinematics block with
// random idling and back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module dh_forward_kinematics_top_test;

  localparam int N_RANDOM = 1100;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int fail_count;
  int pending;
  longint cycle_cnt = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  dhfk_joint_if joint_in();
  dhfk_pos_if   pos_out();

  dh_forward_kinematics_top u_top (.clk(clk), .rst(rst), .joint_in(joint_in.sink),
                                   .pos_out(pos_out.source));

  dh_forward_kinematics_checker u_checker (.clk(clk), .rst(rst), .joint_in(joint_in),
                                           .pos_out(pos_out), .fail_count(fail_count),
                                           .pending(pending));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[dh_forward_kinematics_top] ERROR");
      $finish;
    end
  end

  initial pos_out.ready = 1'b0;
  always @(posedge clk) begin
    if (rst || hold_off) pos_out.ready <= 1'b0;
    else pos_out.ready <= quiet || ($urandom_range(99) >= 28);
  end

  initial begin
    joint_in.valid = 1'b0;
    joint_in.joint_angle = '0;
    joint_in.twist_angle = '0;
    joint_in.link_length = '0;
    joint_in.link_offset = '0;
    joint_in.last_joint = 1'b0;
  end

  task automatic send_joint(logic [15:0] th, logic [15:0] al, logic [31:0] a,
                            logic [31:0] d, logic last);
    while (!quiet && $urandom_range(99) < 28) begin
      joint_in.valid <= 1'b0;
      @(posedge clk);
    end
    joint_in.valid <= 1'b1;
    joint_in.joint_angle <= th;
    joint_in.twist_angle <= al;
    joint_in.link_length <= a;
    joint_in.link_offset <= d;
    joint_in.last_joint <= last;
    @(posedge clk);
    while (!joint_in.ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_len();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [15:0] rand_ang();
    case ($urandom_range(7))
      0: return 16'($urandom_range(3) * 16'h4000 + $urandom_range(8191, 8193));
      1: return 16'($urandom_range(3) * 16'h4000);
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int n;
    int chain_len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: angle extremes, octant edges, length extremes, saturation
    send_joint(16'h0000, 16'h0000, 32'h0, 32'h0, 1'b0);
    send_joint(16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 1'b0);
    send_joint(16'h2000, 16'h2001, 32'h00010000, 32'h00010000, 1'b0);
    send_joint(16'h4000, 16'h6000, 32'h7fffffff, 32'h7fffffff, 1'b0);
    send_joint(16'h8000, 16'hc000, 32'h7fffffff, 32'h7fffffff, 1'b1);
    send_joint(16'h1fff, 16'h3fff, 32'h80000000, 32'h80000000, 1'b0);
    send_joint(16'h0000, 16'h0000, 32'h80000000, 32'h80000000, 1'b1);
    send_joint(16'h5555, 16'haaaa, 32'h55555555, 32'haaaaaaaa, 1'b1);
    for (int i = 0; i < 11; i++)
      send_joint(16'(i * 5957), 16'(i * 3001), 32'h00020000, 32'hffff0000, i == 10);
    // receiver stall: block fills and stops taking joints
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 5; i++) send_joint(rand_ang(), rand_ang(), rand_len(), rand_len(), 0);
    join
    joint_in.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    n = 0;
    while (n < N_RANDOM) begin
      quiet = (n >= 400 && n < 550);
      chain_len = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
      for (int j = 0; j < chain_len; j++) begin
        send_joint(rand_ang(), rand_ang(), rand_len(), rand_len(), j == chain_len - 1);
        n++;
      end
    end
    quiet = 1'b0;
    joint_in.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("[dh_forward_kinematics_top] OK");
    else $display("[dh_forward_kinematics_top] ERROR");
    $finish;
  end

endmodule

// ===== dh_forward_kinematics_top.f =====
rtl/core/dhfk_pkg.sv
rtl/core/dhfk_joint_if.sv
rtl/core/dhfk_pos_if.sv
rtl/core/dhfk_front.sv
rtl/core/dhfk_queue.sv
rtl/core/dhfk_back.sv
rtl/core/dh_forward_kinematics_top.sv
tb/dh_forward_kinematics_checker.sv
tb/dh_forward_kinematics_top_test.sv
